@@ hdl/chenc_pkg.sv @@
`default_nettype none

package chenc_pkg;

    localparam int unsigned SYM_W    = 8;
    localparam int unsigned LEN_IN_W = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PEND_W   = 7;
    localparam int unsigned PAD_W    = 3;

    typedef enum logic [1:0] {
        OP_NEW_TABLE = 2'd0,
        OP_LOAD      = 2'd1,
        OP_ENCODE    = 2'd2,
        OP_FLUSH     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_BAD_LEN        = 2'd1,
        ST_LEN_DECREASED  = 2'd2,
        ST_OVERSUBSCRIBED = 2'd3
    } t_status;

    // control word that travels from the table stage to the packer
    typedef struct packed {
        t_op     op;
        t_status status;
        logic    hit;
    } t_ctl;

    // mask of the n low pending bits
    function automatic logic [PEND_W-1:0] f_pend_mask(input logic [2:0] n);
        logic [PEND_W:0] ones;
        ones = ({{PEND_W{1'b0}}, 1'b1} << n) - {{PEND_W{1'b0}}, 1'b1};
        return ones[PEND_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/chenc_ram.sv @@
`default_nettype none

module chenc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/chenc_table.sv @@
`default_nettype none

module chenc_table
    import chenc_pkg::*;
#(
    parameter int unsigned CW = 32,
    parameter int unsigned LW = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_op                 i_op,
    input  wire logic [SYM_W-1:0]    i_symbol,
    input  wire logic [LEN_IN_W-1:0] i_sym_len,
    output logic                     o_s1_valid,
    input  wire logic                i_s1_take,
    output t_ctl                     o_s1_ctl,
    output logic      [CW-1:0]       o_s1_code,
    output logic      [LW-1:0]       o_s1_len
);

    localparam int unsigned DEPTH = 1 << SYM_W;

    logic             r_s1_valid;
    t_ctl             r_s1_ctl;
    logic [CW-1:0]    r_next;
    logic [LW-1:0]    r_prev;
    logic             r_full;
    logic [DEPTH-1:0] r_loaded;

    logic             accept;
    logic [LW-1:0]    len_w;
    logic [LW-1:0]    diff;
    logic [CW-1:0]    len_mask;
    logic [CW-1:0]    new_code;
    t_status          load_status;
    logic             we;
    logic             re;
    logic [LW+CW-1:0] rdata;

    assign o_ready = !r_s1_valid || i_s1_take;
    assign accept  = i_valid && o_ready;

    // canonical code assignment
    assign len_w    = i_sym_len[LW-1:0];
    assign diff     = len_w - r_prev;
    assign len_mask = {CW{1'b1}} >> (LW'(CW) - len_w);
    assign new_code = (r_next << diff) & len_mask;

    always_comb begin
        if (i_sym_len == '0 || i_sym_len > LEN_IN_W'(CW)) begin
            load_status = ST_BAD_LEN;
        end else if (len_w < r_prev) begin
            load_status = ST_LEN_DECREASED;
        end else if (r_full) begin
            load_status = ST_OVERSUBSCRIBED;
        end else begin
            load_status = ST_OK;
        end
    end

    assign we = accept && (i_op == OP_LOAD) && (load_status == ST_OK);
    assign re = accept && (i_op == OP_ENCODE);

    chenc_ram #(
        .WIDTH (LW + CW),
        .DEPTH (DEPTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_symbol),
        .i_wdata ({len_w, new_code}),
        .i_re    (re),
        .i_raddr (i_symbol),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_next     <= '0;
            r_prev     <= '0;
            r_full     <= 1'b0;
            r_loaded   <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= (i_op != OP_NEW_TABLE);
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
            if (accept && i_op == OP_NEW_TABLE) begin
                r_next   <= '0;
                r_prev   <= '0;
                r_full   <= 1'b0;
                r_loaded <= '0;
            end else if (we) begin
                r_next           <= (new_code + CW'(1)) & len_mask;
                r_prev           <= len_w;
                r_full           <= (new_code == len_mask);
                r_loaded[i_symbol] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl.op     <= i_op;
            r_s1_ctl.status <= load_status;
            r_s1_ctl.hit    <= r_loaded[i_symbol];
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_ctl   = r_s1_ctl;
    assign o_s1_code  = rdata[CW-1:0];
    assign o_s1_len   = rdata[LW+CW-1:CW];

`ifndef SYNTHESIS
    // a held stage must not see its ram data replaced
    a_no_read_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_s1_take) |-> !re)
        else $error("code ram read while stage held");
`endif

endmodule

`default_nettype wire

@@ hdl/chenc_packer.sv @@
`default_nettype none

module chenc_packer
    import chenc_pkg::*;
#(
    parameter int unsigned CW = 32,
    parameter int unsigned LW = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s1_valid,
    output logic                   o_s1_take,
    input  wire t_ctl              i_s1_ctl,
    input  wire logic [CW-1:0]     i_s1_code,
    input  wire logic [LW-1:0]     i_s1_len,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [BYTE_W-1:0] o_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic      [PAD_W-1:0]  o_pad_bits,
    output t_status                o_status
);

    localparam int unsigned AW  = CW + PEND_W;
    localparam int unsigned CNW = $clog2(AW + 1);

    logic [AW-1:0]     r_acc;
    logic [CNW-1:0]    r_cnt;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bvalid;
    logic              r_out_last;
    logic [PAD_W-1:0]  r_out_pad;
    t_status           r_out_status;

    logic [AW-1:0]     n_acc;
    logic [CNW-1:0]    n_cnt;
    logic              emit;
    logic [BYTE_W-1:0] n_byte;
    logic              n_bvalid;
    logic              n_last;
    logic [PAD_W-1:0]  n_pad;
    t_status           n_status;

    logic              busy;
    logic              out_free;
    logic [PEND_W-1:0] pend;
    logic [AW-1:0]     merged_acc;
    logic [CNW-1:0]    merged_cnt;
    logic [AW-1:0]     src_acc;
    logic [CNW-1:0]    src_cnt;
    logic [CNW-1:0]    rem_cnt;
    logic [BYTE_W-1:0] src_byte;

    assign busy     = r_cnt >= CNW'(BYTE_W);
    assign out_free = !r_out_valid || i_ready;
    assign pend     = r_acc[PEND_W-1:0] & f_pend_mask(r_cnt[2:0]);

    // append the new code below the pending bits
    assign merged_acc = (AW'(pend) << i_s1_len) | AW'(i_s1_code);
    assign merged_cnt = CNW'(r_cnt[2:0]) + CNW'(i_s1_len);

    assign src_acc  = busy ? r_acc : merged_acc;
    assign src_cnt  = busy ? r_cnt : merged_cnt;
    assign rem_cnt  = src_cnt - CNW'(BYTE_W);
    assign src_byte = BYTE_W'(src_acc >> rem_cnt);

    always_comb begin
        o_s1_take = 1'b0;
        emit      = 1'b0;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_byte    = src_byte;
        n_bvalid  = 1'b1;
        n_last    = rem_cnt < CNW'(BYTE_W);
        n_pad     = '0;
        n_status  = ST_OK;
        if (busy) begin
            if (out_free) begin
                emit  = 1'b1;
                n_cnt = rem_cnt;
            end
        end else if (i_s1_valid) begin
            unique case (i_s1_ctl.op)
                OP_LOAD: begin
                    if (out_free) begin
                        o_s1_take = 1'b1;
                        emit      = 1'b1;
                        n_byte    = '0;
                        n_bvalid  = 1'b0;
                        n_last    = 1'b1;
                        n_status  = i_s1_ctl.status;
                    end
                end
                OP_ENCODE: begin
                    o_s1_take = 1'b1;
                    if (i_s1_ctl.hit) begin
                        n_acc = merged_acc;
                        n_cnt = merged_cnt;
                        if (merged_cnt >= CNW'(BYTE_W) && out_free) begin
                            emit  = 1'b1;
                            n_cnt = rem_cnt;
                        end
                    end
                end
                OP_FLUSH: begin
                    if (r_cnt == '0) begin
                        o_s1_take = 1'b1;
                    end else if (out_free) begin
                        o_s1_take = 1'b1;
                        emit      = 1'b1;
                        n_cnt     = '0;
                        n_byte    = {pend, 1'b0} << (3'd7 - r_cnt[2:0]);
                        n_last    = 1'b1;
                        n_pad     = PAD_W'(4'd8 - {1'b0, r_cnt[2:0]});
                    end
                end
                default: begin
                    o_s1_take = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_acc <= n_acc;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= n_byte;
            r_out_bvalid <= n_bvalid;
            r_out_last   <= n_last;
            r_out_pad    <= n_pad;
            r_out_status <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte       = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_last       = r_out_last;
    assign o_pad_bits   = r_out_pad;
    assign o_status     = r_out_status;

`ifndef SYNTHESIS
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(AW))
        else $error("bit count beyond accumulator");

    a_take_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s1_take |-> i_s1_valid)
        else $error("take without a staged item");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !out_free) |=> $stable(r_cnt))
        else $error("bit count moved while output blocked");
`endif

endmodule

`default_nettype wire

@@ hdl/canonical_huffman_encoder_core.sv @@
// path: an item is registered in the table stage (code ram read data and control), then in the packer output register
// throughput: 1 item per cycle while each item yields at most one result and m_axis_tready holds
// an encode completing k bytes is emitted a byte at a time while later items wait on the packer
// reset (synchronous, active low) clears the table flags, code state and pending bits
// code ram contents are not cleared; per-symbol loaded flags gate every lookup
`default_nettype none

module canonical_huffman_encoder_core
    import chenc_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // symbol, length
    input  wire logic [1:0]  s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // out_byte, pad_bits, zero fill
    output logic      [2:0]  m_axis_tuser,   // byte_valid, status
    output logic             m_axis_tlast
);

    // code words are MAX_CODE_LEN wide, lengths hold 0..MAX_CODE_LEN
    localparam int unsigned CW = MAX_CODE_LEN;
    localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);

    logic              s1_valid;
    logic              s1_take;
    t_ctl              s1_ctl;
    logic [CW-1:0]     s1_code;
    logic [LW-1:0]     s1_len;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [PAD_W-1:0]  pad_bits;
    t_status           status;

    // table stage: assigns canonical codes on load, looks up code ram on encode
    chenc_table #(
        .CW (CW),
        .LW (LW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (t_op'(s_axis_tuser)),
        .i_symbol   (s_axis_tdata[7:0]),
        .i_sym_len  (s_axis_tdata[15:8]),
        .o_s1_valid (s1_valid),
        .i_s1_take  (s1_take),
        .o_s1_ctl   (s1_ctl),
        .o_s1_code  (s1_code),
        .o_s1_len   (s1_len)
    );

    // packer: merges codes into the bit accumulator, emits bytes msb first
    chenc_packer #(
        .CW (CW),
        .LW (LW)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .o_s1_take    (s1_take),
        .i_s1_ctl     (s1_ctl),
        .i_s1_code    (s1_code),
        .i_s1_len     (s1_len),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (out_byte),
        .o_byte_valid (byte_valid),
        .o_last       (m_axis_tlast),
        .o_pad_bits   (pad_bits),
        .o_status     (status)
    );

    assign m_axis_tdata = {5'd0, pad_bits, out_byte};
    assign m_axis_tuser = {status, byte_valid};

endmodule

`default_nettype wire
